### hdl/c2s_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the arctangent table for the Cartesian to spherical converter.
// Depends on nothing; the design files use it by scoped names.
package c2s_pkg;

	localparam int COORD_W      = 16;
	localparam int SQ_W         = 32;
	localparam int SQRT_IN_W    = 56;
	localparam int SQRT_STEPS   = SQRT_IN_W / 2;
	localparam int ROOT_W       = SQRT_STEPS;
	localparam int REM_W        = ROOT_W + 2;
	localparam int CORDIC_STEPS = 22;
	localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
	localparam int VEC_W        = 50;
	localparam int ACC_W        = 26;
	localparam int ATAN_W       = 22;
	localparam int COORD_DLY    = SQRT_STEPS + 2;
	localparam int FLAG_DLY     = SQRT_STEPS + CORDIC_LAT;
	localparam int PIPE_LAT     = 3 + SQRT_STEPS + CORDIC_LAT + 1;

	localparam logic signed [ACC_W-1:0] ANG_HALF_TURN = ACC_W'(8388608);
	localparam logic [15:0] POLAR_MAX = 16'd32768;

	// atan(2^-i) in units of 2^-24 turn
	function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
		logic [ATAN_W-1:0] val;
		case (idx)
			0:  val = 22'd2097152;
			1:  val = 22'd1238021;
			2:  val = 22'd654136;
			3:  val = 22'd332050;
			4:  val = 22'd166669;
			5:  val = 22'd83416;
			6:  val = 22'd41718;
			7:  val = 22'd20860;
			8:  val = 22'd10430;
			9:  val = 22'd5215;
			10: val = 22'd2608;
			11: val = 22'd1304;
			12: val = 22'd652;
			13: val = 22'd326;
			14: val = 22'd163;
			15: val = 22'd81;
			16: val = 22'd41;
			17: val = 22'd20;
			18: val = 22'd10;
			19: val = 22'd5;
			20: val = 22'd3;
			21: val = 22'd1;
			default: val = '0;
		endcase
		return val;
	endfunction

endpackage

### hdl/cartesian_to_spherical.sv
`timescale 1ns / 1ps
// A request passes capture, squares, sums, root, CORDIC and output register, then shows done high;
// throughput is one request per cycle and busy is always low.
// The depth is set by the 28-stage root of (x^2+y^2)*2^24 feeding a 23-stage CORDIC.
// Reset (arst_n low) clears the valid chain only; data registers are not reset.
// Depends on c2s_pkg, c2s_isqrt and c2s_cordic.
module cartesian_to_spherical (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	output logic               done,
	output logic [15:0]        radius_cyl,
	output logic [15:0]        radius_sph,
	output logic [15:0]        azimuth,
	output logic [15:0]        polar_angle,
	output logic               azimuth_undefined,
	output logic               polar_undefined
);

	// valid chain, one bit per register stage
	logic [c2s_pkg::PIPE_LAT-1:0] vld_q;

	logic signed [c2s_pkg::COORD_W-1:0] x_s1, y_s1, z_s1;
	logic [c2s_pkg::SQ_W-1:0] xx_s2, yy_s2, zz_s2;
	logic signed [2*c2s_pkg::COORD_W-1:0] xx_w, yy_w, zz_w;
	logic [c2s_pkg::SQ_W-1:0] sq_xy_s3, sq_xyz_s3;
	logic az_undef_s3, pol_undef_s3;

	logic signed [c2s_pkg::COORD_W-1:0] x_dly [c2s_pkg::COORD_DLY];
	logic signed [c2s_pkg::COORD_W-1:0] y_dly [c2s_pkg::COORD_DLY];
	logic signed [c2s_pkg::COORD_W-1:0] z_dly [c2s_pkg::COORD_DLY];
	logic [c2s_pkg::FLAG_DLY-1:0] az_undef_dly, pol_undef_dly;
	logic [15:0] rcyl_dly [c2s_pkg::CORDIC_LAT];
	logic [15:0] rsph_dly [c2s_pkg::CORDIC_LAT];

	logic [c2s_pkg::ROOT_W-1:0] rho_root, cyl_root, sph_root;
	logic [c2s_pkg::REM_W-1:0]  rho_rem, cyl_rem, sph_rem;
	logic [15:0] rcyl_rnd, rsph_rnd;

	logic signed [c2s_pkg::VEC_W-1:0] az_px, az_py, pol_px, pol_py;
	logic signed [c2s_pkg::ACC_W-1:0] az_acc, pol_acc;
	logic [24:0] az_sum;
	logic signed [c2s_pkg::ACC_W:0] pol_sum;
	logic [15:0] az_val, pol_val;

	// no backpressure anywhere: a request enters every cycle start is high
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[c2s_pkg::PIPE_LAT-2:0], start & ~busy};
		end
	end
	assign done = vld_q[c2s_pkg::PIPE_LAT-1];

	// stage 1: capture the request
	always_ff @(posedge clk) begin
		x_s1 <= coord_x;
		y_s1 <= coord_y;
		z_s1 <= coord_z;
	end

	// stage 2: three squares, one multiplier each
	assign xx_w = x_s1 * x_s1;
	assign yy_w = y_s1 * y_s1;
	assign zz_w = z_s1 * z_s1;
	always_ff @(posedge clk) begin
		xx_s2 <= xx_w;
		yy_s2 <= yy_w;
		zz_s2 <= zz_w;
	end

	// stage 3: sums of squares and degenerate-point flags
	always_ff @(posedge clk) begin
		sq_xy_s3     <= xx_s2 + yy_s2;
		sq_xyz_s3    <= xx_s2 + yy_s2 + zz_s2;
		az_undef_s3  <= (xx_s2 == '0) && (yy_s2 == '0);
		pol_undef_s3 <= (xx_s2 == '0) && (yy_s2 == '0) && (zz_s2 == '0);
	end

	// hold coordinates and flags alongside the root pipelines
	always_ff @(posedge clk) begin
		x_dly[0] <= x_s1;
		y_dly[0] <= y_s1;
		z_dly[0] <= z_s1;
		for (int k = 1; k < c2s_pkg::COORD_DLY; k++) begin
			x_dly[k] <= x_dly[k-1];
			y_dly[k] <= y_dly[k-1];
			z_dly[k] <= z_dly[k-1];
		end
		az_undef_dly  <= {az_undef_dly[c2s_pkg::FLAG_DLY-2:0], az_undef_s3};
		pol_undef_dly <= {pol_undef_dly[c2s_pkg::FLAG_DLY-2:0], pol_undef_s3};
	end

	// square roots: rho with 12 fraction bits for the polar CORDIC, and both radii
	c2s_isqrt u_rho (
		.clk  (clk),
		.num  ({sq_xy_s3, 24'd0}),
		.root (rho_root),
		.rem  (rho_rem)
	);

	c2s_isqrt u_rcyl (
		.clk  (clk),
		.num  ({24'd0, sq_xy_s3}),
		.root (cyl_root),
		.rem  (cyl_rem)
	);

	c2s_isqrt u_rsph (
		.clk  (clk),
		.num  ({24'd0, sq_xyz_s3}),
		.root (sph_root),
		.rem  (sph_rem)
	);

	// round to nearest: the remainder n - r*r exceeds r exactly when rounding up
	assign rcyl_rnd = cyl_root[15:0] + 16'(cyl_rem > c2s_pkg::REM_W'(cyl_root));
	assign rsph_rnd = sph_root[15:0] + 16'(sph_rem > c2s_pkg::REM_W'(sph_root));

	always_ff @(posedge clk) begin
		rcyl_dly[0] <= rcyl_rnd;
		rsph_dly[0] <= rsph_rnd;
		for (int k = 1; k < c2s_pkg::CORDIC_LAT; k++) begin
			rcyl_dly[k] <= rcyl_dly[k-1];
			rsph_dly[k] <= rsph_dly[k-1];
		end
	end

	// scale the CORDIC operands up; the rho remainder is unused
	assign az_px  = {{(c2s_pkg::VEC_W-46){x_dly[c2s_pkg::COORD_DLY-1][15]}},
		x_dly[c2s_pkg::COORD_DLY-1], 30'd0};
	assign az_py  = {{(c2s_pkg::VEC_W-46){y_dly[c2s_pkg::COORD_DLY-1][15]}},
		y_dly[c2s_pkg::COORD_DLY-1], 30'd0};
	assign pol_px = {{(c2s_pkg::VEC_W-46){z_dly[c2s_pkg::COORD_DLY-1][15]}},
		z_dly[c2s_pkg::COORD_DLY-1], 30'd0};
	assign pol_py = {{(c2s_pkg::VEC_W-46){1'b0}}, rho_root, 18'd0};

	c2s_cordic u_az (
		.clk   (clk),
		.px    (az_px),
		.py    (az_py),
		.angle (az_acc)
	);

	c2s_cordic u_pol (
		.clk   (clk),
		.px    (pol_px),
		.py    (pol_py),
		.angle (pol_acc)
	);

	// azimuth: wrap to one turn, round to 16 bits; a full turn wraps to zero
	assign az_sum = {1'b0, az_acc[23:0]} + 25'd128;
	assign az_val = az_sum[23:8];

	// polar angle: round, then clamp to [0, half turn]
	assign pol_sum = {pol_acc[c2s_pkg::ACC_W-1], pol_acc} + (c2s_pkg::ACC_W+1)'(128);
	always_comb begin
		if (pol_sum < 0) begin
			pol_val = '0;
		end else if (pol_sum[c2s_pkg::ACC_W-1:8] > (c2s_pkg::ACC_W-8)'(c2s_pkg::POLAR_MAX)) begin
			pol_val = c2s_pkg::POLAR_MAX;
		end else begin
			pol_val = pol_sum[23:8];
		end
	end

	// output register; drop angles of degenerate points
	always_ff @(posedge clk) begin
		radius_cyl        <= rcyl_dly[c2s_pkg::CORDIC_LAT-1];
		radius_sph        <= rsph_dly[c2s_pkg::CORDIC_LAT-1];
		azimuth           <= az_undef_dly[c2s_pkg::FLAG_DLY-1] ? 16'd0 : az_val;
		polar_angle       <= pol_undef_dly[c2s_pkg::FLAG_DLY-1] ? 16'd0 : pol_val;
		azimuth_undefined <= az_undef_dly[c2s_pkg::FLAG_DLY-1];
		polar_undefined   <= pol_undef_dly[c2s_pkg::FLAG_DLY-1];
	end

	a_pol_implies_az: assert property (@(posedge clk) disable iff (!arst_n)
		done && polar_undefined |-> azimuth_undefined)
		else $error("polar_undefined without azimuth_undefined");

	a_az_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && azimuth_undefined |-> azimuth == 16'd0 && radius_cyl == 16'd0)
		else $error("undefined azimuth with nonzero angle or radius");

	a_pol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && polar_undefined |-> polar_angle == 16'd0 && radius_sph == 16'd0)
		else $error("undefined polar angle with nonzero angle or radius");

	a_pol_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> polar_angle <= c2s_pkg::POLAR_MAX)
		else $error("polar angle beyond half turn");

endmodule

### hdl/c2s_isqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit integer square root, one root bit per register stage.
// Depends on c2s_pkg for widths and step count.
module c2s_isqrt (
	input  logic                             clk,
	input  logic [c2s_pkg::SQRT_IN_W-1:0]    num,
	output logic [c2s_pkg::ROOT_W-1:0]       root,
	output logic [c2s_pkg::REM_W-1:0]        rem
);

	logic [c2s_pkg::SQRT_IN_W-1:0] num_s  [c2s_pkg::SQRT_STEPS];
	logic [c2s_pkg::REM_W-1:0]     rem_s  [c2s_pkg::SQRT_STEPS];
	logic [c2s_pkg::ROOT_W-1:0]    root_s [c2s_pkg::SQRT_STEPS];

	for (genvar k = 0; k < c2s_pkg::SQRT_STEPS; k++) begin : g_step
		logic [c2s_pkg::SQRT_IN_W-1:0] n_in;
		logic [c2s_pkg::REM_W-1:0]     r_in;
		logic [c2s_pkg::ROOT_W-1:0]    q_in;
		logic [c2s_pkg::REM_W+1:0]     shifted;
		logic [c2s_pkg::REM_W+1:0]     trial;
		logic [c2s_pkg::REM_W+1:0]     diff;
		logic                          fits;

		if (k == 0) begin : g_first
			assign n_in = num;
			assign r_in = '0;
			assign q_in = '0;
		end else begin : g_next
			assign n_in = num_s[k-1];
			assign r_in = rem_s[k-1];
			assign q_in = root_s[k-1];
		end

		// bring down the next bit pair and try (2*root+1)^2 growth
		assign shifted = {r_in, n_in[c2s_pkg::SQRT_IN_W-1 -: 2]};
		assign trial   = {2'b00, q_in, 2'b01};
		assign fits    = (shifted >= trial);
		assign diff    = shifted - trial;

		always_ff @(posedge clk) begin
			num_s[k]  <= {n_in[c2s_pkg::SQRT_IN_W-3:0], 2'b00};
			rem_s[k]  <= fits ? diff[c2s_pkg::REM_W-1:0] : shifted[c2s_pkg::REM_W-1:0];
			root_s[k] <= {q_in[c2s_pkg::ROOT_W-2:0], fits};
		end
	end

	assign root = root_s[c2s_pkg::SQRT_STEPS-1];
	assign rem  = rem_s[c2s_pkg::SQRT_STEPS-1];

endmodule

### hdl/c2s_cordic.sv
`timescale 1ns / 1ps
// Pipelined vectoring CORDIC: angle of (px, py) in units of 2^-24 turn.
// Depends on c2s_pkg for widths and the arctangent table.
module c2s_cordic (
	input  logic                                clk,
	input  logic signed [c2s_pkg::VEC_W-1:0]    px,
	input  logic signed [c2s_pkg::VEC_W-1:0]    py,
	output logic signed [c2s_pkg::ACC_W-1:0]    angle
);

	logic signed [c2s_pkg::VEC_W-1:0] x_s   [c2s_pkg::CORDIC_LAT];
	logic signed [c2s_pkg::VEC_W-1:0] y_s   [c2s_pkg::CORDIC_LAT];
	logic signed [c2s_pkg::ACC_W-1:0] acc_s [c2s_pkg::CORDIC_LAT];

	// fold the left half plane over by a half turn
	always_ff @(posedge clk) begin
		if (px < 0) begin
			x_s[0]   <= -px;
			y_s[0]   <= -py;
			acc_s[0] <= c2s_pkg::ANG_HALF_TURN;
		end else begin
			x_s[0]   <= px;
			y_s[0]   <= py;
			acc_s[0] <= '0;
		end
	end

	for (genvar i = 0; i < c2s_pkg::CORDIC_STEPS; i++) begin : g_iter
		localparam logic signed [c2s_pkg::ACC_W-1:0] ATAN =
			c2s_pkg::ACC_W'(c2s_pkg::atan_entry(i));
		logic signed [c2s_pkg::VEC_W-1:0] dx;
		logic signed [c2s_pkg::VEC_W-1:0] dy;

		assign dx = y_s[i] >>> i;
		assign dy = x_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1]   <= x_s[i] + dx;
				y_s[i+1]   <= y_s[i] - dy;
				acc_s[i+1] <= acc_s[i] + ATAN;
			end else begin
				x_s[i+1]   <= x_s[i] - dx;
				y_s[i+1]   <= y_s[i] + dy;
				acc_s[i+1] <= acc_s[i] - ATAN;
			end
		end
	end

	assign angle = acc_s[c2s_pkg::CORDIC_LAT-1];

endmodule

### tb/cartesian_to_spherical_checker.sv
`timescale 1ns / 1ps
// Checker for the Cartesian to spherical converter: watches requests and results,
// predicts each result in bit-accurate arithmetic and compares. Depends on nothing.
module cartesian_to_spherical_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] coord_x,
	input  logic signed [15:0] coord_y,
	input  logic signed [15:0] coord_z,
	input  logic               done,
	input  logic [15:0]        radius_cyl,
	input  logic [15:0]        radius_sph,
	input  logic [15:0]        azimuth,
	input  logic [15:0]        polar_angle,
	input  logic               azimuth_undefined,
	input  logic               polar_undefined,
	output int                 pending,
	output int                 errors
);

	typedef struct packed {
		logic [15:0] rcyl;
		logic [15:0] rsph;
		logic [15:0] az;
		logic [15:0] pol;
		logic        az_undef;
		logic        pol_undef;
	} point_result_t;

	localparam longint HALF_TURN = 64'sd8388608;

	point_result_t expected_points[$];

	function automatic longint arc_step(input int i);
		longint tab [22] = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
			20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
		return tab[i];
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint unsigned nearest_sqrt(input longint unsigned n);
		longint unsigned r;
		r = floor_sqrt(n);
		if (n - r * r > r) r++;
		return r;
	endfunction

	// Vectoring CORDIC; >>> on signed longint floors toward minus infinity.
	function automatic longint vector_angle(input longint px, input longint py);
		longint acc, dx, dy;
		acc = 0;
		if (px < 0) begin
			px = -px;
			py = -py;
			acc = HALF_TURN;
		end
		for (int i = 0; i < 22; i++) begin
			dx = py >>> i;
			dy = px >>> i;
			if (py >= 0) begin
				px += dx;
				py -= dy;
				acc += arc_step(i);
			end else begin
				px -= dx;
				py += dy;
				acc -= arc_step(i);
			end
		end
		return acc;
	endfunction

	function automatic point_result_t convert_point(input logic signed [15:0] cx,
			input logic signed [15:0] cy, input logic signed [15:0] cz);
		point_result_t r;
		longint x, y, z, a, v;
		longint unsigned sq_xy, sq_xyz, u;
		x = cx;
		y = cy;
		z = cz;
		sq_xy = x * x + y * y;
		sq_xyz = sq_xy + z * z;
		r.az_undef = (x == 0 && y == 0);
		r.pol_undef = r.az_undef && z == 0;
		r.az = '0;
		r.pol = '0;
		if (!r.az_undef) begin
			a = vector_angle(x <<< 30, y <<< 30);
			u = a & 64'hFFFFFF;
			r.az = 16'((u + 128) >> 8);
		end
		if (!r.pol_undef) begin
			a = vector_angle(z <<< 30, longint'(floor_sqrt(sq_xy << 24)) <<< 18);
			v = a + 128;
			if (v < 0) v = 0;
			v = v >>> 8;
			if (v > 32768) v = 32768;
			r.pol = 16'(v);
		end
		r.rcyl = 16'(nearest_sqrt(sq_xy));
		r.rsph = 16'(nearest_sqrt(sq_xyz));
		return r;
	endfunction

	assign pending = expected_points.size();

	always @(posedge clk or negedge arst_n) begin
		point_result_t exp_r, got;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (start && !busy)
				expected_points.push_back(convert_point(coord_x, coord_y, coord_z));
			if (done) begin
				got = '{radius_cyl, radius_sph, azimuth, polar_angle,
					azimuth_undefined, polar_undefined};
				if (expected_points.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					errors <= errors + 1;
				end else begin
					exp_r = expected_points.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch expected rc=%0d rs=%0d az=%0d pol=%0d au=%b pu=%b",
							$time, exp_r.rcyl, exp_r.rsph, exp_r.az, exp_r.pol,
							exp_r.az_undef, exp_r.pol_undef);
						$display("%0t:          actual   rc=%0d rs=%0d az=%0d pol=%0d au=%b pu=%b",
							$time, got.rcyl, got.rsph, got.az, got.pol,
							got.az_undef, got.pol_undef);
						errors <= errors + 1;
					end
				end
			end
		end
	end

endmodule

### tb/cartesian_to_spherical_test.sv
`timescale 1ns / 1ps
// Top of the converter testbench: clock, reset, point stimulus and the verdict.
// Depends on cartesian_to_spherical and cartesian_to_spherical_checker.
module cartesian_to_spherical_test;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               start = 0;
	logic signed [15:0] coord_x = 0;
	logic signed [15:0] coord_y = 0;
	logic signed [15:0] coord_z = 0;
	logic               busy, done;
	logic [15:0]        radius_cyl, radius_sph, azimuth, polar_angle;
	logic               azimuth_undefined, polar_undefined;
	int                 pending, errors;
	longint             cycles = 0;

	localparam int     LATENCY = 60;
	localparam longint CYCLE_LIMIT = 400000;

	cartesian_to_spherical dut (.*);
	cartesian_to_spherical_checker checker_i (.*);

	always #2 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Hold one request until it is taken; drop start only when the caller goes idle.
	task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		start   <= 1;
		coord_x <= x;
		coord_y <= y;
		coord_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic go_idle(input int n);
		start <= 0;
		repeat (n) @(posedge clk);
	endtask

	// Pick a coordinate: extremes, small values near the axes, or anything.
	function automatic logic signed [15:0] pick_coord();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 0;
			3, 4: return 16'($signed($urandom_range(0, 8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int burst;
		logic signed [15:0] corners [6] = '{16'sh8000, 16'sh7FFF, 0, 1, -1, 16'sh4000};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: origin, each axis on both sides, extreme corners, quadrant borders.
		send_point(0, 0, 0);
		send_point(0, 0, 16'sh7FFF);
		send_point(0, 0, 16'sh8000);
		send_point(16'sh7FFF, 0, 0);
		send_point(16'sh8000, 0, 0);
		send_point(0, 16'sh7FFF, 0);
		send_point(0, 16'sh8000, 0);
		send_point(16'sh8000, 16'sh8000, 16'sh8000);
		send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_point(16'sh7FFF, 16'sh8000, 0);
		send_point(-1, -1, 0);
		send_point(1, -1, 1);
		send_point(-1, 1, -1);
		send_point(16'sh7FFF, -1, 0);
		send_point(-1, 0, 0);
		send_point(16'sh8000, -1, 5);
		send_point(1, 0, 0);
		for (int i = 0; i < 6; i++)
			send_point(corners[i], corners[5 - i], corners[(i + 2) % 6]);

		// Wait out the pipeline once with no new requests.
		go_idle(1);
		while (pending != 0) @(posedge clk);

		// Random bursts with random gaps, and long gap-free stretches now and then.
		for (int n = 0; n < 1750; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < 1750; k++, n++)
				send_point(pick_coord(), pick_coord(), pick_coord());
			if ($urandom_range(0, 3) != 0)
				go_idle($urandom_range(1, 12));
		end
		go_idle(1);

		while (pending != 0) @(posedge clk);
		repeat (LATENCY) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
